@@ hw/rtl/crc8w_pkg.sv @@
// shared types, constants and the crc-8 byte step for the word frame checker
`default_nettype none

package crc8w_pkg;

  localparam int unsigned MAX_WORDS   = 32;
  localparam int unsigned INDEX_REACH = 32;
  localparam int unsigned WORD_LIMIT  = (MAX_WORDS < INDEX_REACH) ? MAX_WORDS : INDEX_REACH;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_MSB  = 8'h80;

  localparam logic [5:0] COUNT_LIMIT = 6'(WORD_LIMIT);
  localparam logic [5:0] COUNT_MIN   = 6'd1;

  localparam logic [1:0] PH_HIGH  = 2'd0;
  localparam logic [1:0] PH_LOW   = 2'd1;
  localparam logic [1:0] PH_CHECK = 2'd2;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_CRC_ERR = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
    logic       start_req;
    logic [5:0] word_total;
  } stage_t;

  function automatic logic [7:0] crc_byte_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 8'd0) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/crc8w_ifs.sv @@
// valid/ready channel interfaces for input bytes and result words
`default_nettype none

interface crc8w_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       start_req;
  logic [5:0] word_total;

  modport source (output valid, output rx_byte, output start_req, output word_total,
                  input ready);
  modport sink (input valid, input rx_byte, input start_req, input word_total,
                output ready);
endinterface

interface crc8w_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] data_word;
  logic [4:0]  word_index;
  logic        status;
  logic        last;

  modport source (output valid, output data_word, output word_index, output status,
                  output last, input ready);
  modport sink (input valid, input data_word, input word_index, input status,
                input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/crc8w_in_stage.sv @@
// input register stage for received byte transactions
`default_nettype none

module crc8w_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  crc8w_in_if.sink             in_ch,
  input  wire logic            advance,
  output crc8w_pkg::stage_t    stage
);

  logic       valid_r;
  logic [7:0] rx_byte_r;
  logic       start_req_r;
  logic [5:0] word_total_r;

  assign in_ch.ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      rx_byte_r    <= in_ch.rx_byte;
      start_req_r  <= in_ch.start_req;
      word_total_r <= in_ch.word_total;
    end
  end

  assign stage.valid      = valid_r;
  assign stage.rx_byte    = rx_byte_r;
  assign stage.start_req  = start_req_r;
  assign stage.word_total = word_total_r;

endmodule

`default_nettype wire

@@ hw/rtl/crc8w_frame.sv @@
// frame state, crc check and result register
`default_nettype none

module crc8w_frame (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire crc8w_pkg::stage_t stage,
  output logic                   advance,
  crc8w_out_if.source            out_ch
);

  logic [1:0]  phase_r,  phase_nxt;
  logic [7:0]  high_r,   high_nxt;
  logic [7:0]  low_r,    low_nxt;
  logic [7:0]  crc_r,    crc_nxt;
  logic [5:0]  expect_r, expect_nxt;
  logic [4:0]  index_r,  index_nxt;
  logic        active_r, active_nxt;

  logic        out_valid_r;
  logic [15:0] data_word_r,  data_word_nxt;
  logic [4:0]  word_index_r, word_index_nxt;
  logic        status_r,     status_nxt;
  logic        last_r,       last_nxt;
  logic        produce;

  logic [5:0]  cnt;
  logic [7:0]  crc_step;
  logic        fin;

  assign advance = stage.valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    phase_nxt      = phase_r;
    high_nxt       = high_r;
    low_nxt        = low_r;
    crc_nxt        = crc_r;
    expect_nxt     = expect_r;
    index_nxt      = index_r;
    active_nxt     = active_r;
    produce        = 1'b0;
    data_word_nxt  = 16'd0;
    word_index_nxt = 5'd0;
    status_nxt     = crc8w_pkg::ST_OK;
    last_nxt       = 1'b0;

    cnt = stage.word_total;
    if (cnt == 6'd0) begin
      cnt = crc8w_pkg::COUNT_MIN;
    end
    if (cnt > crc8w_pkg::COUNT_LIMIT) begin
      cnt = crc8w_pkg::COUNT_LIMIT;
    end

    if (stage.start_req) begin
      expect_nxt = cnt;
      index_nxt  = 5'd0;
      phase_nxt  = crc8w_pkg::PH_HIGH;
      crc_nxt    = crc8w_pkg::CRC_INIT;
      active_nxt = 1'b1;
    end

    crc_step = crc8w_pkg::crc_byte_step(crc_nxt, stage.rx_byte);
    fin      = ({1'b0, index_nxt} + 6'd1) >= expect_nxt;

    if (active_nxt) begin
      unique case (phase_nxt)
        crc8w_pkg::PH_HIGH: begin
          high_nxt  = stage.rx_byte;
          crc_nxt   = crc_step;
          phase_nxt = crc8w_pkg::PH_LOW;
        end
        crc8w_pkg::PH_LOW: begin
          low_nxt   = stage.rx_byte;
          crc_nxt   = crc_step;
          phase_nxt = crc8w_pkg::PH_CHECK;
        end
        default: begin
          produce        = 1'b1;
          word_index_nxt = index_nxt;
          phase_nxt      = crc8w_pkg::PH_HIGH;
          if (stage.rx_byte != crc_nxt) begin
            status_nxt = crc8w_pkg::ST_CRC_ERR;
            last_nxt   = 1'b1;
            active_nxt = 1'b0;
          end else begin
            data_word_nxt = {high_nxt, low_nxt};
            last_nxt      = fin;
            if (fin) begin
              active_nxt = 1'b0;
            end else begin
              index_nxt = index_nxt + 5'd1;
            end
          end
          crc_nxt = crc8w_pkg::CRC_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= crc8w_pkg::PH_HIGH;
      high_r      <= 8'd0;
      low_r       <= 8'd0;
      crc_r       <= crc8w_pkg::CRC_INIT;
      expect_r    <= 6'd0;
      index_r     <= 5'd0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        phase_r  <= phase_nxt;
        high_r   <= high_nxt;
        low_r    <= low_nxt;
        crc_r    <= crc_nxt;
        expect_r <= expect_nxt;
        index_r  <= index_nxt;
        active_r <= active_nxt;
      end
      if (advance && produce) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      data_word_r  <= data_word_nxt;
      word_index_r <= word_index_nxt;
      status_r     <= status_nxt;
      last_r       <= last_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.data_word  = data_word_r;
  assign out_ch.word_index = word_index_r;
  assign out_ch.status     = status_r;
  assign out_ch.last       = last_r;

endmodule

`default_nettype wire

@@ hw/rtl/crc8_word_frame_checker.sv @@
// top level of the crc-8 word frame checker
// usage:
//   in_ch carries one received byte per transaction with start_req and word_total;
//   start_req marks the high byte of word 0 and loads the word count (0 reads as 1,
//   counts above 32 saturate). bytes come as high, low, crc-8 (poly 0x31, init 0xff).
//   out_ch carries one transaction per check byte: the word and its index, or a
//   crc error with status set; last marks the final word or the error.
//   after the final word or an error, bytes are dropped until the next start.
// timing:
//   one byte per cycle sustained while out_ch keeps up; a check byte goes through
//   the input register, then the combinational crc step and frame logic, into the
//   result register.
// reset:
//   synchronous active-low rst_n empties both registers and leaves the block idle.
// stall:
//   while a result waits on out_ch the input register still fills; once both hold,
//   in_ch.ready drops until the result is taken.
`default_nettype none

module crc8_word_frame_checker (
  input  wire logic   clk,
  input  wire logic   rst_n,
  crc8w_in_if.sink    in_ch,
  crc8w_out_if.source out_ch
);

  crc8w_pkg::stage_t stage;
  logic              advance;

  crc8w_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  crc8w_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
